### sv/hbgi_pkg.sv
// Payload types and codes for the hypergraph bipartition gain initializer.
`default_nettype none

package hbgi_pkg;

  localparam int VIDX_W = 12;
  localparam int WIN_W  = 16;
  localparam int EDGE_W = 16;
  localparam int SUM_W  = 32;

  localparam logic OP_PIN  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [VIDX_W-1:0] vertex_index;
    logic              vertex_side;
    logic [WIN_W-1:0]  edge_weight;
    logic              last_pin;
  } req_t;

  typedef struct packed {
    logic              result_kind;
    logic [EDGE_W-1:0] edge_number;
    logic              edge_is_cut;
    logic              pin_overflow;
    logic [SUM_W-1:0]  free_gain;
    logic [SUM_W-1:0]  internal_weight;
    logic              on_boundary;
  } rsp_t;

endpackage

`default_nettype wire

### sv/hypergraph_bipartition_gain_init.sv
// Top level: pin buffering, cut test and per-vertex gain updates over a shared adder.
//
//   channel | dir | handshake            | payload
//   req     | in  | req_valid, req_stall | req  (pin or vertex read)
//   rsp     | out | rsp_valid, rsp_stall | rsp  (edge result or read answer)
//
// After reset the vertex store is swept to zero, one entry a cycle, with req_stall
// high; the sweep covers the first MAX_VERTICES entries (at most 4096).
// A non-final pin is taken in S_IDLE. A closing pin starts a walk over the buffered
// pins: each pin whose vertex is in range has its store entry read and then written
// back through the shared adder; other pins are skipped. The edge result follows.
// A read answer is registered in S_READ_OUT. req_stall is high whenever the sequencer
// is busy; a result waiting on rsp_stall does not stall non-final pins.
`default_nettype none

module hypergraph_bipartition_gain_init
  import hbgi_pkg::*;
#(
  parameter int MAX_VERTICES = 4096,
  parameter int MAX_PINS     = 64,
  parameter int WEIGHT_BITS  = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  req_t      req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  localparam int VCNT = (MAX_VERTICES < (1 << VIDX_W)) ? MAX_VERTICES : (1 << VIDX_W);
  localparam int VAW  = $clog2(VCNT);
  localparam int PAW  = $clog2(MAX_PINS);
  localparam int PCW  = $clog2(MAX_PINS + 1);
  localparam int WB   = (WEIGHT_BITS < WIN_W) ? WEIGHT_BITS : WIN_W;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_PIN_RD, S_VTX_RD, S_UPDATE, S_EDGE_OUT, S_READ_OUT
  } state_t;

  typedef struct packed {
    logic             bnd;
    logic [SUM_W-1:0] internal;
    logic [SUM_W-1:0] free;
  } vword_t;

  typedef struct packed {
    logic [VIDX_W-1:0] vertex;
    logic              side;
  } pin_t;

  state_t             state;
  logic [VAW-1:0]     clr;
  logic [PCW-1:0]     pin_count;
  logic [PCW-1:0]     idx;
  logic               overflow_seen;
  logic [1:0]         side_cnt0;
  logic [1:0]         side_cnt1;
  logic [WB-1:0]      weight;
  logic [EDGE_W-1:0]  edge_counter;
  logic               rd_in_range;

  pin_t               pin_mem [MAX_PINS];
  pin_t               pin_rd;
  vword_t             vmem [VCNT];
  vword_t             vmem_rd;

  logic               accept;
  logic               out_free;
  logic               rsp_load;
  logic               buf_full;
  logic               pin_we;
  logic [PCW-1:0]     idx_inc;
  logic               idx_adv;
  logic [PAW-1:0]     pin_raddr;
  logic               pin_in_range;
  logic               vmem_re;
  logic [VAW-1:0]     vmem_raddr;
  logic               vmem_we;
  logic [VAW-1:0]     vmem_waddr;
  vword_t             vmem_wdata;
  logic               cut;
  logic               alone;
  logic [SUM_W-1:0]   add_a;
  logic [SUM_W-1:0]   add_b;
  logic [SUM_W:0]     add_sum;
  logic [SUM_W-1:0]   add_sat;
  logic [1:0]         cnt0_next;
  logic [1:0]         cnt1_next;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign rsp_load  = ((state == S_EDGE_OUT) || (state == S_READ_OUT)) && out_free;
  assign buf_full  = (pin_count == PCW'(MAX_PINS));
  assign pin_we    = accept && (req.opcode == OP_PIN) && !buf_full;

  assign idx_inc   = idx + 1'b1;
  assign pin_in_range = ({{(32-VIDX_W){1'b0}}, pin_rd.vertex} < 32'(MAX_VERTICES));
  assign idx_adv   = (state == S_UPDATE) || ((state == S_VTX_RD) && !pin_in_range);
  assign pin_raddr = idx_adv ? idx_inc[PAW-1:0] : idx[PAW-1:0];

  assign cut   = (side_cnt0 != 2'd0) && (side_cnt1 != 2'd0);
  assign alone = pin_rd.side ? (side_cnt1 == 2'd1) : (side_cnt0 == 2'd1);

  // Shared saturating adder: free gain on a cut edge, internal weight otherwise.
  always_comb begin
    add_a   = cut ? vmem_rd.free : vmem_rd.internal;
    add_b   = (!cut || alone) ? SUM_W'(weight) : '0;
    add_sum = {1'b0, add_a} + {1'b0, add_b};
    add_sat = add_sum[SUM_W] ? '1 : add_sum[SUM_W-1:0];
  end

  always_comb begin
    vmem_re    = 1'b0;
    vmem_raddr = pin_rd.vertex[VAW-1:0];
    if (state == S_IDLE) begin
      vmem_re    = accept && (req.opcode == OP_READ);
      vmem_raddr = req.vertex_index[VAW-1:0];
    end else if (state == S_VTX_RD) begin
      vmem_re = pin_in_range;
    end
  end

  always_comb begin
    vmem_we    = 1'b0;
    vmem_waddr = pin_rd.vertex[VAW-1:0];
    vmem_wdata = vmem_rd;
    if (state == S_CLEAR) begin
      vmem_we    = 1'b1;
      vmem_waddr = clr;
      vmem_wdata = '0;
    end else if (state == S_UPDATE) begin
      vmem_we = 1'b1;
      if (cut) begin
        vmem_wdata.bnd  = 1'b1;
        vmem_wdata.free = add_sat;
      end else begin
        vmem_wdata.internal = add_sat;
      end
    end
  end

  always_comb begin
    cnt0_next = side_cnt0;
    cnt1_next = side_cnt1;
    if (pin_we) begin
      if (req.vertex_side) begin
        cnt1_next = (side_cnt1 == 2'd2) ? 2'd2 : side_cnt1 + 2'd1;
      end else begin
        cnt0_next = (side_cnt0 == 2'd2) ? 2'd2 : side_cnt0 + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pin_we) begin
      pin_mem[pin_count[PAW-1:0]] <= '{vertex: req.vertex_index, side: req.vertex_side};
    end
    pin_rd <= pin_mem[pin_raddr];
  end

  always_ff @(posedge clk) begin
    if (vmem_we) begin
      vmem[vmem_waddr] <= vmem_wdata;
    end
    if (vmem_re) begin
      vmem_rd <= vmem[vmem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr           <= '0;
      pin_count     <= '0;
      idx           <= '0;
      overflow_seen <= 1'b0;
      side_cnt0     <= 2'd0;
      side_cnt1     <= 2'd0;
      edge_counter  <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == VAW'(VCNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (req.opcode == OP_READ) begin
              rd_in_range <= ({{(32-VIDX_W){1'b0}}, req.vertex_index} < 32'(MAX_VERTICES));
              state       <= S_READ_OUT;
            end else begin
              side_cnt0 <= cnt0_next;
              side_cnt1 <= cnt1_next;
              if (pin_we) begin
                pin_count <= pin_count + 1'b1;
              end else begin
                overflow_seen <= 1'b1;
              end
              if (req.last_pin) begin
                weight <= req.edge_weight[WB-1:0];
                idx    <= '0;
                state  <= S_PIN_RD;
              end
            end
          end
        end
        S_PIN_RD: begin
          state <= S_VTX_RD;
        end
        S_VTX_RD: begin
          if (pin_in_range) begin
            state <= S_UPDATE;
          end else begin
            // skip: vertex has no store entry
            idx <= idx_inc;
            if (idx_inc == pin_count) begin
              state <= S_EDGE_OUT;
            end
          end
        end
        S_UPDATE: begin
          idx   <= idx_inc;
          state <= (idx_inc == pin_count) ? S_EDGE_OUT : S_VTX_RD;
        end
        S_EDGE_OUT: begin
          if (out_free) begin
            rsp <= '{result_kind: KIND_EDGE, edge_number: edge_counter, edge_is_cut: cut,
                     pin_overflow: overflow_seen, free_gain: '0, internal_weight: '0,
                     on_boundary: 1'b0};
            edge_counter         <= edge_counter + 1'b1;
            pin_count            <= '0;
            overflow_seen        <= 1'b0;
            side_cnt0            <= 2'd0;
            side_cnt1            <= 2'd0;
            state                <= S_IDLE;
          end
        end
        S_READ_OUT: begin
          if (out_free) begin
            rsp <= '{result_kind: KIND_READ, edge_number: '0, edge_is_cut: 1'b0,
                     pin_overflow: 1'b0,
                     free_gain: rd_in_range ? vmem_rd.free : '0,
                     internal_weight: rd_in_range ? vmem_rd.internal : '0,
                     on_boundary: rd_in_range && vmem_rd.bnd};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_idx_in_buffer: assert property (@(posedge clk) disable iff (rst)
    (state == S_VTX_RD || state == S_UPDATE) |-> (idx < pin_count))
    else $error("pin walk index past buffered pins");

  a_counts_follow_pins: assert property (@(posedge clk) disable iff (rst)
    (pin_count == '0) |-> (side_cnt0 == 2'd0 && side_cnt1 == 2'd0))
    else $error("side counts nonzero with empty pin buffer");

  a_update_next: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE) |=> (state == S_VTX_RD || state == S_EDGE_OUT))
    else $error("update not followed by next pin or edge result");

  a_edge_count_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_EDGE_OUT && out_free) |=> (edge_counter == $past(edge_counter) + 1'b1))
    else $error("edge counter did not advance on edge result");

endmodule

`default_nettype wire
